### rtl/mpf_pkg.sv
package mpf_pkg;

    // Fixed field widths.
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 2;

    // Constant bytes of the frame.
    localparam logic [BYTE_W-1:0] START_BYTE  = 8'h5F;
    localparam logic [BYTE_W-1:0] BASE_LENGTH = 8'h05;

    // Configuration register indexes.
    localparam logic [1:0] REG_SRC_ADDR = 2'd0;
    localparam logic [1:0] REG_DST_ADDR = 2'd1;

    // Byte positions inside a packet; data bytes follow the destination.
    localparam logic [IDX_W-1:0] POS_START = 4'd0;
    localparam logic [IDX_W-1:0] POS_LEN   = 4'd1;
    localparam logic [IDX_W-1:0] POS_TYPE  = 4'd2;
    localparam logic [IDX_W-1:0] POS_SRC   = 4'd3;
    localparam logic [IDX_W-1:0] POS_DST   = 4'd4;
    localparam logic [IDX_W-1:0] POS_DATA  = 4'd5;

    // Message type codes.
    localparam logic [BYTE_W-1:0] TYPE_1 = 8'd1;
    localparam logic [BYTE_W-1:0] TYPE_2 = 8'd2;
    localparam logic [BYTE_W-1:0] TYPE_3 = 8'd3;
    localparam logic [BYTE_W-1:0] TYPE_4 = 8'd4;
    localparam logic [BYTE_W-1:0] TYPE_5 = 8'd5;
    localparam logic [BYTE_W-1:0] TYPE_6 = 8'd6;
    localparam logic [BYTE_W-1:0] TYPE_7 = 8'd7;

    // Decoded request: number of data bytes and whether the type is known.
    typedef struct packed {
        logic             known;
        logic [CNT_W-1:0] count;
    } t_type_info;

    // Sequencer to datapath control for one emitted byte.
    typedef struct packed {
        logic             emit;
        logic [IDX_W-1:0] idx;
        logic             last;
        logic             err;
        logic             add;
    } t_seq_ctl;

    // Data byte count for a message type.
    function automatic t_type_info decode_type(input logic [BYTE_W-1:0] t);
        t_type_info info;
        info.known = 1'b1;
        info.count = 2'd0;
        unique case (t)
            TYPE_1, TYPE_2, TYPE_3: info.count = 2'd1;
            TYPE_6:                 info.count = 2'd3;
            TYPE_4, TYPE_5, TYPE_7: info.count = 2'd0;
            default:                info.known = 1'b0;
        endcase
        return info;
    endfunction

endpackage

### rtl/mpf_seq.sv
module mpf_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_err,
    input  logic [mpf_pkg::IDX_W-1:0] i_last_idx,
    input  logic                      i_adv,
    output logic                      o_busy,
    output mpf_pkg::t_seq_ctl         o_ctl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SEND = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    logic [1:0]                r_state, n_state;
    logic [mpf_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [mpf_pkg::IDX_W-1:0] r_last_idx;
    logic                      w_at_last;

    assign w_at_last = (r_idx == r_last_idx);

    // One byte leaves whenever the output register can take it.
    always_comb begin
        o_ctl.emit = (r_state != ST_IDLE) && i_adv;
        o_ctl.idx  = r_idx;
        o_ctl.err  = (r_state == ST_ERR);
        o_ctl.last = (r_state == ST_SEND) && w_at_last;
        o_ctl.add  = (r_state == ST_SEND) && (r_idx != mpf_pkg::POS_START) && !w_at_last;
    end

    assign o_busy = (r_state != ST_IDLE);

    // Next state: a request starts a packet or a one-byte error report.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = i_err ? ST_ERR : ST_SEND;
                    n_idx   = mpf_pkg::POS_START;
                end
            end
            ST_SEND: begin
                if (i_adv) begin
                    if (w_at_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_ERR: begin
                if (i_adv) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Packet length is captured with the request.
    always_ff @(posedge i_clk) begin
        if (i_start && r_state == ST_IDLE) begin
            r_last_idx <= i_last_idx;
        end
    end

endmodule

### rtl/mpf_acc.sv
module mpf_acc (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic                       i_add,
    input  logic [mpf_pkg::BYTE_W-1:0] i_byte,
    output logic [mpf_pkg::BYTE_W-1:0] o_check
);

    logic [mpf_pkg::BYTE_W-1:0] r_sum;

    // Shared 8-bit adder: one covered byte per cycle joins the sum while i_add is high.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_sum <= '0;
        end else if (i_add) begin
            r_sum <= r_sum + i_byte;
        end
    end

    // 0xFF minus the sum is the bitwise complement.
    assign o_check = ~r_sum;

endmodule

### rtl/message_packet_framer_unit.sv
// Message packet framer. A request (type plus three data bytes) is turned into a
// framed packet: 0x5F, length, type, source, destination, zero, one or three data
// bytes, and a checksum flagged by o_last_byte. Types 1-3 carry one data byte,
// type 6 three, types 4, 5 and 7 none; any other type yields a single transaction
// with o_type_error set and o_out_byte zero. The packet leaves one byte per cycle
// while i_ready is high; the byte sequencer steps through the frame, and the single
// checksum adder sums the covered bytes. o_ready is low from acceptance until the
// last byte has entered the output register; the next request may then be taken
// while that byte still waits.
// Configuration writes are index 0 source address, index 1 destination address;
// other indexes are ignored.
module message_packet_framer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_msg_type,
    input  logic [7:0] i_data_first,
    input  logic [7:0] i_data_second,
    input  logic [7:0] i_data_third,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_byte,
    output logic       o_type_error,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic [mpf_pkg::BYTE_W-1:0] r_src_addr;
    logic [mpf_pkg::BYTE_W-1:0] r_dst_addr;
    logic [mpf_pkg::BYTE_W-1:0] r_type;
    logic [mpf_pkg::BYTE_W-1:0] r_data [0:2];
    logic [mpf_pkg::CNT_W-1:0]  r_count;

    logic                       r_out_valid;
    logic [mpf_pkg::BYTE_W-1:0] r_out_byte;
    logic                       r_out_last;
    logic                       r_out_err;

    logic                       w_in_accept;
    logic                       w_adv;
    logic                       w_busy;
    mpf_pkg::t_type_info        w_info;
    logic [mpf_pkg::IDX_W-1:0]  w_last_idx;
    logic [mpf_pkg::IDX_W-1:0]  w_data_off;
    logic [mpf_pkg::BYTE_W-1:0] w_byte;
    logic [mpf_pkg::BYTE_W-1:0] w_check;
    mpf_pkg::t_seq_ctl          w_ctl;

    assign o_ready     = !w_busy;
    assign w_in_accept = i_valid && !w_busy;
    assign w_adv       = !r_out_valid || i_ready;

    // Request decode: last byte position is the data start plus the data count.
    assign w_info     = mpf_pkg::decode_type(i_msg_type);
    assign w_last_idx = mpf_pkg::POS_DATA + {{(mpf_pkg::IDX_W-mpf_pkg::CNT_W){1'b0}}, w_info.count};

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_addr <= '0;
            r_dst_addr <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mpf_pkg::REG_SRC_ADDR: r_src_addr <= i_cfg_data;
                mpf_pkg::REG_DST_ADDR: r_dst_addr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the request for the length of the packet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type  <= '0;
            r_count <= '0;
        end else if (w_in_accept) begin
            r_type  <= i_msg_type;
            r_count <= w_info.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_data[0] <= i_data_first;
            r_data[1] <= i_data_second;
            r_data[2] <= i_data_third;
        end
    end

    mpf_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_accept),
        .i_err      (!w_info.known),
        .i_last_idx (w_last_idx),
        .i_adv      (w_adv),
        .o_busy     (w_busy),
        .o_ctl      (w_ctl)
    );

    // Byte select for the current frame position.
    assign w_data_off = w_ctl.idx - mpf_pkg::POS_DATA;

    always_comb begin
        w_byte = '0;
        if (w_ctl.err) begin
            w_byte = '0;
        end else if (w_ctl.last) begin
            w_byte = w_check;
        end else begin
            case (w_ctl.idx)
                mpf_pkg::POS_START: w_byte = mpf_pkg::START_BYTE;
                mpf_pkg::POS_LEN:
                    w_byte = mpf_pkg::BASE_LENGTH
                             + {{(mpf_pkg::BYTE_W-mpf_pkg::CNT_W){1'b0}}, r_count};
                mpf_pkg::POS_TYPE:  w_byte = r_type;
                mpf_pkg::POS_SRC:   w_byte = r_src_addr;
                mpf_pkg::POS_DST:   w_byte = r_dst_addr;
                default:            w_byte = r_data[w_data_off[1:0]];
            endcase
        end
    end

    mpf_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_in_accept),
        .i_add   (w_ctl.emit && w_ctl.add),
        .i_byte  (w_byte),
        .o_check (w_check)
    );

    // Output register separates the sequencer from the downstream stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.emit) begin
            r_out_byte <= w_byte;
            r_out_last <= w_ctl.last;
            r_out_err  <= w_ctl.err;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_last_byte  = r_out_last;
    assign o_type_error = r_out_err;

    // The checksum byte never carries the error flag.
    a_last_not_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_last_byte && o_type_error))
        else $error("checksum byte flagged as type error");

    // An accepted request starts the checksum from an empty sum.
    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (w_check == 8'hFF))
        else $error("running sum not cleared at request");

    // After the final byte of a packet or an error report the block is free.
    a_free_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.emit && (w_ctl.last || w_ctl.err)) |=> !w_busy)
        else $error("sequencer still busy after final byte");

    // No byte is emitted unless a request is in progress.
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.emit |-> (w_busy && w_adv))
        else $error("byte emitted while idle or stalled");

endmodule
